>>> sv/cts_pkg.sv
// Shared types, codes and constants of the cooperative task scheduler.
package cts_pkg;

  localparam int unsigned MaxTasksDef = 8;
  localparam int unsigned CountW      = 8;
  localparam int unsigned SlotW       = 3;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_DEL  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EV_DUE       = 3'd0,
    EV_ADDED     = 3'd1,
    EV_FULL      = 3'd2,
    EV_DELETED   = 3'd3,
    EV_UNDEFINED = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [CountW-1:0] delay;
    logic [CountW-1:0] period;
    logic [SlotW-1:0]  task_id;
  } in_t;

  typedef struct packed {
    event_e           event_res;
    logic [SlotW-1:0] slot;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [CountW-1:0] delay;
    logic [CountW-1:0] period;
  } slot_ent_t;

endpackage

>>> sv/cts_slot_mem.sv
// Slot table memory: one write port, one registered read port.
module cts_slot_mem import cts_pkg::*; #(
  parameter int unsigned Depth = MaxTasksDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  slot_ent_t        wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output slot_ent_t        rdata_o
);

  slot_ent_t mem_q [Depth];
  slot_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cooperative_task_scheduler_top.sv
// Top level of the cooperative task scheduler: control, valid marks and result register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o  | in_i  (func, delay, period, task_id)
//   out     | output    | out_valid_o / out_ready_i| out_o (event_res, slot, last)
//
// Add and delete items give one beat each.
// A tick walks the slot memory, one slot per cycle (through the single registered read
// port), then scans the due marks, one slot per cycle while the output is not stalled,
// giving one beat per due slot.
// Reset clears all valid marks and the next free slot; no memory clear pass.
// A stalled output holds the due scan; input is taken only when idle and the result
// register can load.
module cooperative_task_scheduler_top import cts_pkg::*; #(
  parameter int unsigned MaxTasks = MaxTasksDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     scan_cnt_q, scan_cnt_d;
  logic [IdxW-1:0]     emit_idx_q, emit_idx_d;
  logic [MaxTasks-1:0] due_q, due_d;
  logic [MaxTasks-1:0] valid_q, valid_d;
  logic [CntW-1:0]     nfree_q, nfree_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  slot_ent_t       mem_wdata, mem_rdata;

  logic                in_acc, out_free, scan_last, proc_en, hit, emit_hit, emit_last;
  logic [IdxW-1:0]     proc_idx, del_idx;
  logic [CountW-1:0]   dec;
  logic [MaxTasks-1:0] emit_rest;
  logic                del_ok;

  cts_slot_mem #(
    .Depth (MaxTasks),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  assign scan_last = scan_cnt_q == CntW'(MaxTasks);
  assign proc_idx  = IdxW'(scan_cnt_q - CntW'(1));
  assign proc_en   = (scan_cnt_q != '0) && valid_q[proc_idx];
  assign dec       = mem_rdata.delay - CountW'(1);
  assign hit       = dec == '0;
  assign emit_hit  = due_q[emit_idx_q];
  assign emit_rest = (due_q >> emit_idx_q) >> 1;
  assign emit_last = emit_rest == '0;
  assign del_idx   = IdxW'(in_i.task_id);
  assign del_ok    = (32'(in_i.task_id) < 32'(MaxTasks)) && valid_q[del_idx];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.func == FUNC_TICK) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (due_q == '0) begin
          state_d = ST_IDLE;
        end else if (out_free && ((emit_hit && emit_last) ||
                                  emit_idx_q == IdxW'(MaxTasks - 1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    scan_cnt_d  = scan_cnt_q;
    emit_idx_d  = emit_idx_q;
    due_d       = due_q;
    valid_d     = valid_q;
    nfree_d     = nfree_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_acc) begin
          case (in_i.func)
            FUNC_ADD: begin
              out_valid_d = 1'b1;
              if (nfree_q < CntW'(MaxTasks)) begin
                mem_we                       = 1'b1;
                mem_waddr                    = IdxW'(nfree_q);
                mem_wdata.delay              = in_i.delay + CountW'(1);
                mem_wdata.period             = in_i.period;
                valid_d[IdxW'(nfree_q)]      = 1'b1;
                nfree_d                      = nfree_q + CntW'(1);
                out_d.event_res              = EV_ADDED;
                out_d.slot                   = SlotW'(nfree_q);
              end else begin
                out_d.event_res = EV_FULL;
                out_d.slot      = '0;
              end
              out_d.last = 1'b1;
            end
            FUNC_DEL: begin
              out_valid_d = 1'b1;
              if (del_ok) begin
                valid_d[del_idx] = 1'b0;
                out_d.event_res  = EV_DELETED;
              end else begin
                out_d.event_res = EV_UNDEFINED;
              end
              out_d.slot = in_i.task_id;
              out_d.last = 1'b1;
            end
            FUNC_TICK: begin
              scan_cnt_d = '0;
              due_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_re     = scan_cnt_q < CntW'(MaxTasks);
        mem_raddr  = IdxW'(scan_cnt_q);
        scan_cnt_d = scan_cnt_q + CntW'(1);
        emit_idx_d = '0;
        if (proc_en) begin
          mem_we           = 1'b1;
          mem_waddr        = proc_idx;
          mem_wdata.period = mem_rdata.period;
          if (hit) begin
            mem_wdata.delay = mem_rdata.period;
            due_d[proc_idx] = 1'b1;
            if (mem_rdata.period == '0) begin
              valid_d[proc_idx] = 1'b0;
            end
          end else begin
            mem_wdata.delay = dec;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_idx_d = emit_idx_q + IdxW'(1);
          if (emit_hit) begin
            out_valid_d     = 1'b1;
            out_d.event_res = EV_DUE;
            out_d.slot      = SlotW'(emit_idx_q);
            out_d.last      = emit_last;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      emit_idx_q  <= '0;
      due_q       <= '0;
      valid_q     <= '0;
      nfree_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      emit_idx_q  <= emit_idx_d;
      due_q       <= due_d;
      valid_q     <= valid_d;
      nfree_q     <= nfree_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.func == FUNC_TICK |=> state_q == ST_SCAN)
    else $error("tick did not start the slot walk");

  a_scan_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_last |=> state_q == ST_EMIT)
    else $error("slot walk did not hand over to the due scan");

  a_nfree_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfree_q <= CntW'(MaxTasks))
    else $error("next free slot beyond table");

  a_nonlast_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> state_q == ST_EMIT && out_q.event_res == EV_DUE)
    else $error("non-final beat outside due scan");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("input ready while busy");

endmodule

>>> sim/cooperative_task_scheduler_top_tb.sv
// Testbench of the cooperative task scheduler: random stimulus, predictor and beat checker.
module cooperative_task_scheduler_top_tb;
  import cts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned QuietFrom = 3000;
  localparam int unsigned QuietTo   = 6000;
  localparam int unsigned DrainWait = 4 * MaxTasksDef + 16;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_o;

  in_t  item_q[$];
  out_t event_q[$];
  int   err_cnt;
  int   cyc_cnt;

  logic              tsk_valid[MaxTasksDef];
  logic [CountW-1:0] tsk_count[MaxTasksDef];
  logic [CountW-1:0] tsk_period[MaxTasksDef];
  logic              tsk_pending[MaxTasksDef];
  logic [3:0]        next_slot;

  cooperative_task_scheduler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  function automatic logic idle_now();
    if (cyc_cnt >= QuietFrom && cyc_cnt < QuietTo) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < 26);
  endfunction

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 50) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic void push_event(event_e ev, logic [SlotW-1:0] s, logic lst);
    out_t r;
    r.event_res = ev;
    r.slot      = s;
    r.last      = lst;
    event_q.push_back(r);
  endfunction

  function automatic void drop_slot(int i);
    tsk_valid[i]   = 1'b0;
    tsk_count[i]   = '0;
    tsk_period[i]  = '0;
    tsk_pending[i] = 1'b0;
  endfunction

  function automatic void predict_events(in_t it);
    int   n;
    int   pos;
    out_t r;
    n   = 0;
    pos = 0;
    case (it.func)
      FUNC_ADD: begin
        if (next_slot < MaxTasksDef) begin
          tsk_valid[next_slot[SlotW-1:0]]   = 1'b1;
          tsk_count[next_slot[SlotW-1:0]]   = it.delay + 8'd1;
          tsk_period[next_slot[SlotW-1:0]]  = it.period;
          tsk_pending[next_slot[SlotW-1:0]] = 1'b0;
          push_event(EV_ADDED, next_slot[SlotW-1:0], 1'b1);
          next_slot = next_slot + 4'd1;
        end else begin
          push_event(EV_FULL, '0, 1'b1);
        end
      end
      FUNC_DEL: begin
        if (tsk_valid[it.task_id]) begin
          drop_slot(int'(it.task_id));
          push_event(EV_DELETED, it.task_id, 1'b1);
        end else begin
          push_event(EV_UNDEFINED, it.task_id, 1'b1);
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < MaxTasksDef; i++) begin
          if (tsk_valid[i]) begin
            tsk_count[i] = tsk_count[i] - 8'd1;
            if (tsk_count[i] == '0) begin
              tsk_pending[i] = 1'b1;
              tsk_count[i]   = tsk_period[i];
            end
          end
        end
        for (int i = 0; i < MaxTasksDef; i++) begin
          if (tsk_pending[i]) begin
            push_event(EV_DUE, i[SlotW-1:0], 1'b0);
            pos = event_q.size() - 1;
            n++;
            tsk_pending[i] = 1'b0;
            if (tsk_period[i] == '0) begin
              drop_slot(i);
            end
          end
        end
        if (n > 0) begin
          r = event_q[pos];
          r.last = 1'b1;
          event_q[pos] = r;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] f, input logic [CountW-1:0] d,
                            input logic [CountW-1:0] p, input logic [SlotW-1:0] id);
    in_t it;
    it.func    = func_e'(f);
    it.delay   = d;
    it.period  = p;
    it.task_id = id;
    item_q.push_back(it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_events(in_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (item_q.size() != 0 && !idle_now()) begin
          in_valid_i <= 1'b1;
          in_i       <= item_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_ev;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (event_q.size() == 0) begin
          report($sformatf("unexpected beat ev=%0d slot=%0d last=%0b",
                           out_o.event_res, out_o.slot, out_o.last));
        end else begin
          exp_ev = event_q.pop_front();
          if (out_o.event_res !== exp_ev.event_res) begin
            report($sformatf("event_res %0d, want %0d", out_o.event_res, exp_ev.event_res));
          end
          if (out_o.slot !== exp_ev.slot) begin
            report($sformatf("slot %0d, want %0d", out_o.slot, exp_ev.slot));
          end
          if (out_o.last !== exp_ev.last) begin
            report($sformatf("last %0b, want %0b", out_o.last, exp_ev.last));
          end
        end
      end
      out_ready_i <= !idle_now();
    end
  end

  initial begin
    int unsigned r;
    logic [CountW-1:0] d;
    logic [CountW-1:0] p;
    err_cnt   = 0;
    cyc_cnt   = 0;
    next_slot = '0;
    for (int i = 0; i < MaxTasksDef; i++) begin
      drop_slot(i);
    end
    rst_ni = 1'b0;

    queue_item(FUNC_ADD, 8'd0, 8'd1, 3'd5);
    queue_item(FUNC_ADD, 8'd1, 8'd0, 3'd0);
    queue_item(FUNC_ADD, 8'd255, 8'd255, 3'd7);
    queue_item(FUNC_ADD, 8'd2, 8'd3, 3'd2);
    queue_item(FUNC_TICK, 8'd255, 8'd255, 3'd7);
    queue_item(FUNC_TICK, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_TICK, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_DEL, 8'd0, 8'd0, 3'd7);
    queue_item(FUNC_DEL, 8'd255, 8'd255, 3'd3);
    queue_item(FUNC_DEL, 8'd0, 8'd0, 3'd3);
    queue_item(FuncUnused, 8'd255, 8'd255, 3'd7);
    queue_item(FuncUnused, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_TICK, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_ADD, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_TICK, 8'd0, 8'd0, 3'd0);
    queue_item(FUNC_TICK, 8'd0, 8'd0, 3'd0);

    for (int i = 0; i < 490; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70 || (r >= 88 && r < 95 && i < 380)) begin
        queue_item(FUNC_TICK, 8'($urandom), 8'($urandom), 3'($urandom));
      end else if (r < 88) begin
        d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        queue_item(FUNC_ADD, d, p, 3'($urandom));
      end else if (r < 95) begin
        queue_item(FUNC_DEL, 8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)));
      end else begin
        queue_item(FuncUnused, 8'($urandom), 8'($urandom), 3'($urandom));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (event_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (event_q.size() != 0) begin
      report($sformatf("%0d expected beats never came", event_q.size()));
    end
    if (err_cnt == 0) begin
      $display("[cooperative_task_scheduler_top] OK");
    end else begin
      $display("[cooperative_task_scheduler_top] ERROR");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("[cooperative_task_scheduler_top] ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/cts_pkg.sv
sv/cts_slot_mem.sv
sv/cooperative_task_scheduler_top.sv
sim/cooperative_task_scheduler_top_tb.sv
